### hw/rtl/vdi_pkg.sv
// Shared constants, types and state encoding for the vertex dedup indexer.
package vdi_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int WORD_W      = 32;
    localparam int IDX_W       = 10;

    typedef struct packed {
        logic [WORD_W-1:0] pos_x;
        logic [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0] pos_z;
        logic [WORD_W-1:0] color_r;
        logic [WORD_W-1:0] color_g;
        logic [WORD_W-1:0] color_b;
        logic [WORD_W-1:0] normal_x;
        logic [WORD_W-1:0] normal_y;
        logic [WORD_W-1:0] normal_z;
    } vertex_t;

    localparam int VERTEX_W = $bits(vertex_t);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } vdi_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } vdi_cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_done;
        logic out_free;
    } vdi_stat_t;

endpackage

### hw/rtl/vdi_if.sv
// Valid/ready channel interfaces for vertex beats and result beats.
interface vdi_in_if;
    logic        valid;
    logic        ready;
    logic        mesh_start;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] color_r;
    logic [31:0] color_g;
    logic [31:0] color_b;
    logic [31:0] normal_x;
    logic [31:0] normal_y;
    logic [31:0] normal_z;

    modport source (
        output valid, mesh_start, pos_x, pos_y, pos_z,
        output color_r, color_g, color_b, normal_x, normal_y, normal_z,
        input  ready
    );
    modport sink (
        input  valid, mesh_start, pos_x, pos_y, pos_z,
        input  color_r, color_g, color_b, normal_x, normal_y, normal_z,
        output ready
    );
endinterface

interface vdi_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] vertex_index;
    logic       is_new;
    logic       overflow;

    modport source (
        output valid, vertex_index, is_new, overflow,
        input  ready
    );
    modport sink (
        input  valid, vertex_index, is_new, overflow,
        output ready
    );
endinterface

### hw/rtl/vdi_ctrl.sv
// Controller state machine: accepts a vertex, runs the table scan, issues the result.
module vdi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  vdi_pkg::vdi_stat_t stat,
    output vdi_pkg::vdi_cmd_t  cmd
);
    import vdi_pkg::*;

    vdi_state_t state_reg;
    vdi_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((stat.hit || stat.scan_done) && stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan   = !stat.hit && !stat.scan_done;
                cmd.finish = (stat.hit || stat.scan_done) && stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/vdi_datapath.sv
// Datapath: unique-vertex store, entry count, scan pipeline and result register.
module vdi_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  vdi_pkg::vdi_cmd_t          cmd,
    output vdi_pkg::vdi_stat_t         stat,
    input  logic                       mesh_start,
    input  vdi_pkg::vertex_t           vertex_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [vdi_pkg::IDX_W-1:0]  vertex_index,
    output logic                       is_new,
    output logic                       overflow
);
    import vdi_pkg::*;

    logic [VERTEX_W-1:0] mem [TABLE_DEPTH];

    logic [VERTEX_W-1:0] vtx_reg;
    logic [VERTEX_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [CNT_W-1:0]    rd_addr_reg;
    logic [CNT_W-1:0]    rd_addr_next;
    logic [ADDR_W-1:0]   cmp_addr_reg;
    logic                cmp_pend_reg;
    logic                cmp_pend_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [IDX_W-1:0]    res_index_reg;
    logic                res_new_reg;
    logic                res_ovf_reg;

    logic issue;
    logic hit;
    logic full;
    logic store;

    assign issue = cmd.scan && (rd_addr_reg < cnt_reg);
    assign hit   = cmp_pend_reg && (rd_data_reg == vtx_reg);
    assign full  = (cnt_reg == CNT_W'(TABLE_DEPTH));
    assign store = cmd.finish && !hit && !full;

    assign stat.hit       = hit;
    assign stat.scan_done = !cmp_pend_reg && (rd_addr_reg >= cnt_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cnt_next      = cnt_reg;
        rd_addr_next  = rd_addr_reg;
        cmp_pend_next = cmp_pend_reg;
        if (cmd.load)
        begin
            if (mesh_start)
            begin
                cnt_next = '0;
            end
            rd_addr_next  = '0;
            cmp_pend_next = 1'b0;
        end
        else if (cmd.scan)
        begin
            cmp_pend_next = issue;
            if (issue)
            begin
                rd_addr_next = rd_addr_reg + CNT_W'(1);
            end
        end
        if (store)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rd_addr_reg   <= '0;
            cmp_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rd_addr_reg   <= rd_addr_next;
            cmp_pend_reg  <= cmp_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vtx_reg <= vertex_in;
        end
        if (issue)
        begin
            cmp_addr_reg <= rd_addr_reg[ADDR_W-1:0];
        end
        if (cmd.finish)
        begin
            if (hit)
            begin
                res_index_reg <= IDX_W'(cmp_addr_reg);
                res_new_reg   <= 1'b0;
                res_ovf_reg   <= 1'b0;
            end
            else if (full)
            begin
                res_index_reg <= '0;
                res_new_reg   <= 1'b0;
                res_ovf_reg   <= 1'b1;
            end
            else
            begin
                res_index_reg <= IDX_W'(cnt_reg);
                res_new_reg   <= 1'b1;
                res_ovf_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= vtx_reg;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr_reg[ADDR_W-1:0]];
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = res_index_reg;
    assign is_new       = res_new_reg;
    assign overflow     = res_ovf_reg;

endmodule

### hw/rtl/vertex_dedup_indexer.sv
// Top level of the vertex dedup indexer: controller, datapath and channel wiring.
//
// Usage: each beat on the vertex channel carries one vertex (nine 32-bit float
// bit patterns plus mesh_start). Each vertex yields exactly one beat on the
// result channel: the index of the matching stored vertex, or of the newly
// appended one with is_new set, or overflow with index zero when the table
// is full and the vertex is unknown. mesh_start empties the table first.
// Search: the store is searched linearly, one entry per cycle through a
// registered memory read port.
// Flow: one vertex at a time; the next vertex is accepted in the cycle
// after the previous result is loaded into the output register.
// Reset: the entry count clears at once; the store itself is not cleared and
// no entry above the count is ever read.
// Stall: a result waits in the output register while the receiver holds off;
// the controller holds in its scan state and the vertex channel stays not
// ready until the output register frees.
module vertex_dedup_indexer (
    input  logic clk,
    input  logic rst_n,
    vdi_in_if.sink    vertex,
    vdi_out_if.source result
);
    import vdi_pkg::*;

    vdi_cmd_t  cmd;
    vdi_stat_t stat;
    vertex_t   vertex_in;

    assign vertex_in.pos_x    = vertex.pos_x;
    assign vertex_in.pos_y    = vertex.pos_y;
    assign vertex_in.pos_z    = vertex.pos_z;
    assign vertex_in.color_r  = vertex.color_r;
    assign vertex_in.color_g  = vertex.color_g;
    assign vertex_in.color_b  = vertex.color_b;
    assign vertex_in.normal_x = vertex.normal_x;
    assign vertex_in.normal_y = vertex.normal_y;
    assign vertex_in.normal_z = vertex.normal_z;

    vdi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vertex.valid),
        .in_ready (vertex.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vdi_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .mesh_start   (vertex.mesh_start),
        .vertex_in    (vertex_in),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .vertex_index (result.vertex_index),
        .is_new       (result.is_new),
        .overflow     (result.overflow)
    );

endmodule

### hw/rtl/vdi_checker.sv
// Port-level checker for the vertex dedup indexer and its bind to the top level.
module vdi_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [9:0] vertex_index,
    input logic       is_new,
    input logic       overflow
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(vertex_index) && $stable(is_new)
            && $stable(overflow))
        else $error("result payload changed while stalled");

    a_new_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_new && overflow))
        else $error("result flagged both new and overflow");

    a_ovf_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> vertex_index == 10'd0)
        else $error("overflow result with nonzero index");

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .vertex_index (result.vertex_index),
    .is_new       (result.is_new),
    .overflow     (result.overflow)
);

### sim/tb.sv
// Testbench for vertex_dedup_indexer: bit-exact lookup, mesh restart, full table, backpressure.
`timescale 1ns / 100ps

module tb;
    import vdi_pkg::*;

    localparam int          CYCLE_LIMIT = 6_000_000;
    localparam int          SETTLE_CYCLES = TABLE_DEPTH + 8;
    localparam logic [31:0] FP_POS_ZERO = 32'h0000_0000;
    localparam logic [31:0] FP_NEG_ZERO = 32'h8000_0000;
    localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
    localparam logic [31:0] FP_POS_INF  = 32'h7F80_0000;
    localparam logic [31:0] FP_QNAN     = 32'h7FC0_0001;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             is_new;
        logic             overflow;
    } lookup_t;

    logic clk = 1'b0;
    logic rst_n;

    vdi_in_if  vin ();
    vdi_out_if vout ();

    vertex_dedup_indexer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .vertex (vin),
        .result (vout)
    );

    vertex_t     known_vertices [TABLE_DEPTH];
    int unsigned known_count;
    lookup_t     expected_lookups [$];
    int          mismatch_count;
    int          cycle_count;
    int          hold_off_left;
    bit          idle_on;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic lookup_t lookup_vertex(input logic start, input vertex_t v);
        lookup_t     r;
        bit          hit;
        int unsigned k;
        r   = '0;
        hit = 1'b0;
        if (start)
            known_count = 0;
        for (k = 0; k < known_count && !hit; k++)
        begin
            if (known_vertices[k] == v)
            begin
                r.index = IDX_W'(k);
                hit     = 1'b1;
            end
        end
        if (!hit)
        begin
            if (known_count < TABLE_DEPTH)
            begin
                r.index                     = IDX_W'(known_count);
                r.is_new                    = 1'b1;
                known_vertices[known_count] = v;
                known_count++;
            end
            else
                r.overflow = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0: return FP_POS_ZERO;
            1: return FP_NEG_ZERO;
            2: return FP_ONE;
            3: return FP_POS_INF;
            4: return FP_QNAN;
            5: return ALL_ONES;
            default: return $urandom;
        endcase
    endfunction

    function automatic vertex_t random_vertex();
        vertex_t v;
        v.pos_x    = random_word();
        v.pos_y    = random_word();
        v.pos_z    = random_word();
        v.color_r  = random_word();
        v.color_g  = random_word();
        v.color_b  = random_word();
        v.normal_x = random_word();
        v.normal_y = random_word();
        v.normal_z = random_word();
        return v;
    endfunction

    function automatic vertex_t flip_bit(input vertex_t v, input int b);
        logic [VERTEX_W-1:0] flat;
        flat    = v;
        flat[b] = ~flat[b];
        return vertex_t'(flat);
    endfunction

    function automatic vertex_t uniform_vertex(input logic [31:0] w);
        return vertex_t'({9{w}});
    endfunction

    task automatic send_vertex(input logic start, input vertex_t v);
        int      gap;
        lookup_t want;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap       = $urandom_range(1, 5);
            vin.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        vin.valid      = 1'b1;
        vin.mesh_start = start;
        vin.pos_x      = v.pos_x;
        vin.pos_y      = v.pos_y;
        vin.pos_z      = v.pos_z;
        vin.color_r    = v.color_r;
        vin.color_g    = v.color_g;
        vin.color_b    = v.color_b;
        vin.normal_x   = v.normal_x;
        vin.normal_y   = v.normal_y;
        vin.normal_z   = v.normal_z;
        @(posedge clk);
        while (!vin.ready)
            @(posedge clk);
        want = lookup_vertex(start, v);
        expected_lookups.insert(expected_lookups.size(), want);
    endtask

    task automatic note_mismatch(input string what, input lookup_t want, input lookup_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected index %0d new %0b ovf %0b, got index %0d new %0b ovf %0b",
                     $realtime, what, want.index, want.is_new, want.overflow,
                     got.index, got.is_new, got.overflow);
    endtask

    always @(posedge clk)
    begin : result_check
        lookup_t want;
        lookup_t got;
        if (rst_n && vout.valid && vout.ready)
        begin
            got.index    = vout.vertex_index;
            got.is_new   = vout.is_new;
            got.overflow = vout.overflow;
            if (expected_lookups.size() == 0)
                note_mismatch("result beat with nothing pending", '0, got);
            else
            begin
                want = expected_lookups.pop_front();
                if (got.index !== want.index || got.is_new !== want.is_new
                    || got.overflow !== want.overflow)
                    note_mismatch("lookup mismatch", want, got);
            end
        end
    end

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        vout.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                vout.ready = 1'b0;
                hold_off_left--;
            end
            else if (stall_left > 0)
            begin
                vout.ready = 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                vout.ready = 1'b0;
                stall_left = $urandom_range(1, 5) - 1;
            end
            else
                vout.ready = 1'b1;
        end
    end

    task automatic test_bit_exact_match();
        idle_on = 1'b1;
        send_vertex(1'b1, uniform_vertex(FP_POS_ZERO));
        send_vertex(1'b0, uniform_vertex(FP_NEG_ZERO));
        send_vertex(1'b0, uniform_vertex(FP_POS_ZERO));
        send_vertex(1'b0, uniform_vertex(ALL_ONES));
        send_vertex(1'b0, uniform_vertex(FP_QNAN));
        send_vertex(1'b0, uniform_vertex(FP_QNAN));
        send_vertex(1'b0, flip_bit(uniform_vertex(ALL_ONES), 0));
        send_vertex(1'b0, flip_bit(uniform_vertex(ALL_ONES), VERTEX_W - 1));
        send_vertex(1'b0, uniform_vertex(FP_NEG_ZERO));
        send_vertex(1'b0, flip_bit(uniform_vertex(FP_POS_INF), 100));
        send_vertex(1'b0, flip_bit(uniform_vertex(ALL_ONES), 0));
    endtask

    task automatic test_mesh_start();
        idle_on = 1'b1;
        send_vertex(1'b1, uniform_vertex(ALL_ONES));
        send_vertex(1'b0, uniform_vertex(FP_POS_ZERO));
        send_vertex(1'b0, uniform_vertex(ALL_ONES));
        send_vertex(1'b1, uniform_vertex(ALL_ONES));
        send_vertex(1'b0, uniform_vertex(ALL_ONES));
        send_vertex(1'b0, uniform_vertex(FP_ONE));
    endtask

    task automatic test_backpressure();
        vertex_t pool [$];
        vertex_t v;
        int      i;
        idle_on       = 1'b0;
        hold_off_left = 400;
        for (i = 0; i < 40; i++)
        begin
            if (i > 0 && $urandom_range(0, 2) == 0)
                v = pool[$urandom_range(0, pool.size() - 1)];
            else
            begin
                v = random_vertex();
                pool.insert(pool.size(), v);
            end
            send_vertex(i == 0, v);
        end
    endtask

    task automatic test_full_table();
        vertex_t filled [TABLE_DEPTH];
        vertex_t v;
        int      k;
        idle_on = 1'b1;
        for (k = 0; k < TABLE_DEPTH; k++)
        begin
            filled[k]       = random_vertex();
            filled[k].pos_x = k;
            send_vertex(k == 0, filled[k]);
        end
        for (k = 0; k < 3; k++)
        begin
            v       = random_vertex();
            v.pos_x = 32'hFFFF_0000 + k;
            send_vertex(1'b0, v);
        end
        send_vertex(1'b0, filled[0]);
        send_vertex(1'b0, filled[TABLE_DEPTH - 1]);
        send_vertex(1'b0, filled[$urandom_range(1, TABLE_DEPTH - 2)]);
        send_vertex(1'b0, flip_bit(filled[TABLE_DEPTH - 1], 250));
        send_vertex(1'b1, filled[5]);
        send_vertex(1'b0, filled[0]);
        send_vertex(1'b0, filled[5]);
    endtask

    task automatic test_random_meshes(input int n_items, input bit with_idle);
        vertex_t pool [$];
        vertex_t v;
        logic    start;
        int      sent;
        int      mesh_len;
        int      i;
        sent = 0;
        while (sent < n_items)
        begin
            mesh_len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 120)
                                                    : $urandom_range(2, 30);
            idle_on  = with_idle && ($urandom_range(0, 3) != 0);
            for (i = 0; i < mesh_len && sent < n_items; i++)
            begin
                start = 1'b0;
                if (i == 0)
                begin
                    start = 1'b1;
                    if (pool.size() > 0 && $urandom_range(0, 3) == 0)
                        v = pool[$urandom_range(0, pool.size() - 1)];
                    else
                        v = random_vertex();
                    pool.delete();
                    pool.insert(pool.size(), v);
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3:
                        begin
                            v = random_vertex();
                            pool.insert(pool.size(), v);
                        end
                        4, 5, 6:
                            v = pool[$urandom_range(0, pool.size() - 1)];
                        7:
                        begin
                            v = flip_bit(pool[$urandom_range(0, pool.size() - 1)],
                                         $urandom_range(0, VERTEX_W - 1));
                            pool.insert(pool.size(), v);
                        end
                        8:
                        begin
                            v = pool[$urandom_range(0, pool.size() - 1)];
                            if ($urandom_range(0, 3) == 0)
                            begin
                                start = 1'b1;
                                pool.delete();
                                pool.insert(pool.size(), v);
                            end
                        end
                        default:
                        begin
                            v = vertex_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                           $urandom, $urandom, $urandom, $urandom});
                            pool.insert(pool.size(), v);
                        end
                    endcase
                end
                send_vertex(start, v);
                sent++;
            end
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        vin.valid = 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        idle_on        = 1'b0;
        hold_off_left  = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        known_count    = 0;
        vin.valid      = 1'b0;
        vin.mesh_start = 1'b0;
        vin.pos_x      = '0;
        vin.pos_y      = '0;
        vin.pos_z      = '0;
        vin.color_r    = '0;
        vin.color_g    = '0;
        vin.color_b    = '0;
        vin.normal_x   = '0;
        vin.normal_y   = '0;
        vin.normal_z   = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_bit_exact_match();
        test_mesh_start();
        test_backpressure();
        test_full_table();
        test_random_meshes(40, 1'b1);
        test_random_meshes(20, 1'b0);
        drain_results();

        if (mismatch_count == 0 && expected_lookups.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
